@@ rtl/core/mcbm_pkg.sv @@
// ----------------------------------------------------------------------------
// mcbm_pkg
// Types, codes and helpers shared by the multi-channel bounded mailbox.
// ----------------------------------------------------------------------------
package mcbm_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int QUEUE_DEPTH  = 16;
	localparam int DATA_WIDTH   = 32;

	// payload field widths
	localparam int OP_W     = 3;
	localparam int CHAN_W   = 3;
	localparam int WORD_W   = 32;
	localparam int LIMIT_W  = 5;
	localparam int STATUS_W = 2;

	// internal widths
	localparam int CH_IW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// operation codes
	localparam logic [OP_W-1:0] OP_OPEN      = 3'd0;
	localparam logic [OP_W-1:0] OP_CLOSE     = 3'd1;
	localparam logic [OP_W-1:0] OP_SEND      = 3'd2;
	localparam logic [OP_W-1:0] OP_RECEIVE   = 3'd3;
	localparam logic [OP_W-1:0] OP_BROADCAST = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_CHANNEL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [CHAN_W-1:0]  channel;
		logic [WORD_W-1:0]  send_data;
		logic [LIMIT_W-1:0] limit;
	} mcbm_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   recv_data;
		logic [CHAN_W-1:0]   slot;
	} mcbm_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic exec;
		logic read_done;
		logic bcast_step;
		logic load_out;
	} mcbm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic recv_go;
		logic bcast_go;
		logic scan_last;
	} mcbm_stat_t;

	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
		if (32'(p) + 1 >= QUEUE_DEPTH) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [CH_IW-1:0] c,
			input logic [PTR_W-1:0] p);
		return ADDR_W'(32'(c) * QUEUE_DEPTH + 32'(p));
	endfunction

endpackage

@@ rtl/core/multi_channel_bounded_mailbox.sv @@
// ----------------------------------------------------------------------------
// Sequence: each op is latched on accept, executed, and its result loaded into the
// output register; a receive that pops adds a registered word store read, and a
// broadcast that pushes adds a sweep, one sweep step per slot.
// One transaction at a time: the next req is taken the cycle after the result is
// loaded; a waiting result holds the input.
// Reset: arst_n asynchronously closes every slot and clears pointers and fill counts.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// multi_channel_bounded_mailbox
// Fixed table of channel slots, each a bounded FIFO in a shared word store.
// ----------------------------------------------------------------------------
module multi_channel_bounded_mailbox (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mcbm_pkg::mcbm_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mcbm_pkg::mcbm_rsp_t rsp
);

	mcbm_pkg::mcbm_cmd_t  cmd;
	mcbm_pkg::mcbm_stat_t stat;

	mcbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mcbm_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

@@ rtl/core/mcbm_ram.sv @@
// ----------------------------------------------------------------------------
// mcbm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mcbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/mcbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcbm_ctrl
// Sequencer of the mailbox: takes one transaction, steps the datapath
// through execute, store read or broadcast sweep, then hands off the result.
// ----------------------------------------------------------------------------
module mcbm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  mcbm_pkg::mcbm_stat_t stat,
	output mcbm_pkg::mcbm_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_BCAST = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       load_out;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	// result register frees up in the same cycle it is taken
	assign load_out  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		cmd.latch_in   = req_valid && req_ready;
		cmd.exec       = (state_q == S_EXEC);
		cmd.read_done  = (state_q == S_READ);
		cmd.bcast_step = (state_q == S_BCAST);
		cmd.load_out   = load_out;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.recv_go) begin
					state_d = S_READ;
				end else if (stat.bcast_go) begin
					state_d = S_BCAST;
				end else begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				state_d = S_DONE;
			end
			S_BCAST: begin
				if (stat.scan_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/mcbm_datapath.sv @@
// ----------------------------------------------------------------------------
// mcbm_datapath
// Slot table, per-slot queue pointers and fill counts, shared word store,
// and the result and output registers.
// ----------------------------------------------------------------------------
module mcbm_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mcbm_pkg::mcbm_req_t  req,
	output mcbm_pkg::mcbm_rsp_t  rsp,
	input  mcbm_pkg::mcbm_cmd_t  cmd,
	output mcbm_pkg::mcbm_stat_t stat
);

	mcbm_pkg::mcbm_req_t req_q;
	mcbm_pkg::mcbm_rsp_t res_q;
	mcbm_pkg::mcbm_rsp_t res_d;
	mcbm_pkg::mcbm_rsp_t rsp_q;

	logic                        slot_open_q  [mcbm_pkg::NUM_CHANNELS];
	logic [mcbm_pkg::CNT_W-1:0]  slot_limit_q [mcbm_pkg::NUM_CHANNELS];
	logic [mcbm_pkg::PTR_W-1:0]  rd_ptr_q     [mcbm_pkg::NUM_CHANNELS];
	logic [mcbm_pkg::PTR_W-1:0]  wr_ptr_q     [mcbm_pkg::NUM_CHANNELS];
	logic [mcbm_pkg::CNT_W-1:0]  fill_q       [mcbm_pkg::NUM_CHANNELS];
	logic [mcbm_pkg::CH_IW-1:0]  scan_q;

	logic [mcbm_pkg::CH_IW-1:0]  ch_idx;
	logic                        ch_open;
	logic                        ch_room;
	logic                        ch_nonempty;
	logic                        free_found;
	logic [mcbm_pkg::CH_IW-1:0]  low_free_slot;
	logic                        any_open;
	logic                        all_room;
	logic [mcbm_pkg::CNT_W-1:0]  lim_sat;
	logic                        send_go;
	logic                        recv_go;
	logic                        bcast_go;
	logic                        bcast_wr;

	logic                              ram_we;
	logic [mcbm_pkg::ADDR_W-1:0]       ram_waddr;
	logic [mcbm_pkg::ADDR_W-1:0]       ram_raddr;
	logic [mcbm_pkg::DATA_WIDTH-1:0]   ram_rdata;

	assign ch_idx      = req_q.channel[mcbm_pkg::CH_IW-1:0];
	assign ch_open     = (32'(req_q.channel) < mcbm_pkg::NUM_CHANNELS) && slot_open_q[ch_idx];
	assign ch_room     = fill_q[ch_idx] < slot_limit_q[ch_idx];
	assign ch_nonempty = (fill_q[ch_idx] != '0);
	assign lim_sat     = (32'(req_q.limit) > mcbm_pkg::QUEUE_DEPTH) ?
		mcbm_pkg::CNT_W'(mcbm_pkg::QUEUE_DEPTH) : mcbm_pkg::CNT_W'(req_q.limit);

	// lowest free slot, plus the broadcast room check over all open slots
	always_comb begin
		free_found    = 1'b0;
		low_free_slot = '0;
		any_open      = 1'b0;
		all_room      = 1'b1;
		for (int i = mcbm_pkg::NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!slot_open_q[i]) begin
				free_found    = 1'b1;
				low_free_slot = mcbm_pkg::CH_IW'(i);
			end else begin
				any_open = 1'b1;
				if (fill_q[i] >= slot_limit_q[i]) begin
					all_room = 1'b0;
				end
			end
		end
	end

	assign send_go  = (req_q.op == mcbm_pkg::OP_SEND) && ch_open && ch_room;
	assign recv_go  = (req_q.op == mcbm_pkg::OP_RECEIVE) && ch_open && ch_nonempty;
	assign bcast_go = (req_q.op == mcbm_pkg::OP_BROADCAST) && any_open && all_room;
	assign bcast_wr = cmd.bcast_step && slot_open_q[scan_q];

	always_comb begin
		stat.recv_go   = recv_go;
		stat.bcast_go  = bcast_go;
		stat.scan_last = (scan_q == mcbm_pkg::CH_IW'(mcbm_pkg::NUM_CHANNELS - 1));
	end

	always_comb begin
		res_d.status    = mcbm_pkg::ST_NO_CHANNEL;
		res_d.recv_data = '0;
		res_d.slot      = '0;
		case (req_q.op)
			mcbm_pkg::OP_OPEN: begin
				if (free_found) begin
					res_d.status = mcbm_pkg::ST_OK;
					res_d.slot   = mcbm_pkg::CHAN_W'(low_free_slot);
				end else begin
					res_d.status = mcbm_pkg::ST_TABLE_FULL;
				end
			end
			mcbm_pkg::OP_CLOSE: begin
				if (ch_open) begin
					res_d.status = mcbm_pkg::ST_OK;
				end
			end
			mcbm_pkg::OP_SEND: begin
				if (ch_open) begin
					res_d.status = ch_room ? mcbm_pkg::ST_OK : mcbm_pkg::ST_WOULD_BLOCK;
				end
			end
			mcbm_pkg::OP_RECEIVE: begin
				if (ch_open) begin
					res_d.status = ch_nonempty ? mcbm_pkg::ST_OK : mcbm_pkg::ST_WOULD_BLOCK;
				end
			end
			mcbm_pkg::OP_BROADCAST: begin
				if (!any_open) begin
					res_d.status = mcbm_pkg::ST_NO_CHANNEL;
				end else if (!all_room) begin
					res_d.status = mcbm_pkg::ST_WOULD_BLOCK;
				end else begin
					res_d.status = mcbm_pkg::ST_OK;
				end
			end
			default: begin
				res_d.status = mcbm_pkg::ST_NO_CHANNEL;
			end
		endcase
	end

	// word store write: send in execute, or one slot per broadcast sweep step
	assign ram_we    = (cmd.exec && send_go) || bcast_wr;
	assign ram_waddr = cmd.bcast_step ? mcbm_pkg::store_addr(scan_q, wr_ptr_q[scan_q]) :
		mcbm_pkg::store_addr(ch_idx, wr_ptr_q[ch_idx]);
	assign ram_raddr = mcbm_pkg::store_addr(ch_idx, rd_ptr_q[ch_idx]);

	mcbm_ram #(
		.WIDTH(mcbm_pkg::DATA_WIDTH),
		.DEPTH(mcbm_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_q.send_data[mcbm_pkg::DATA_WIDTH-1:0]),
		.re    (cmd.exec && recv_go),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcbm_pkg::NUM_CHANNELS; i++) begin
				slot_open_q[i]  <= 1'b0;
				slot_limit_q[i] <= '0;
				rd_ptr_q[i]     <= '0;
				wr_ptr_q[i]     <= '0;
				fill_q[i]       <= '0;
			end
			scan_q <= '0;
		end else if (cmd.exec) begin
			scan_q <= '0;
			case (req_q.op)
				mcbm_pkg::OP_OPEN: begin
					if (free_found) begin
						slot_open_q[low_free_slot]  <= 1'b1;
						slot_limit_q[low_free_slot] <= lim_sat;
						rd_ptr_q[low_free_slot]     <= '0;
						wr_ptr_q[low_free_slot]     <= '0;
						fill_q[low_free_slot]       <= '0;
					end
				end
				mcbm_pkg::OP_CLOSE: begin
					if (ch_open) begin
						slot_open_q[ch_idx] <= 1'b0;
						rd_ptr_q[ch_idx]    <= '0;
						wr_ptr_q[ch_idx]    <= '0;
						fill_q[ch_idx]      <= '0;
					end
				end
				mcbm_pkg::OP_SEND: begin
					if (send_go) begin
						wr_ptr_q[ch_idx] <= mcbm_pkg::next_pos(wr_ptr_q[ch_idx]);
						fill_q[ch_idx]   <= fill_q[ch_idx] + mcbm_pkg::CNT_W'(1);
					end
				end
				mcbm_pkg::OP_RECEIVE: begin
					if (recv_go) begin
						rd_ptr_q[ch_idx] <= mcbm_pkg::next_pos(rd_ptr_q[ch_idx]);
						fill_q[ch_idx]   <= fill_q[ch_idx] - mcbm_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.bcast_step) begin
			scan_q <= scan_q + mcbm_pkg::CH_IW'(1);
			if (bcast_wr) begin
				wr_ptr_q[scan_q] <= mcbm_pkg::next_pos(wr_ptr_q[scan_q]);
				fill_q[scan_q]   <= fill_q[scan_q] + mcbm_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end else if (cmd.read_done) begin
			res_q.recv_data <= mcbm_pkg::WORD_W'(ram_rdata);
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/core/mcbm_checker.sv @@
// ----------------------------------------------------------------------------
// mcbm_checker
// Port-level checks of the mailbox, bound to the top level.
// ----------------------------------------------------------------------------
module mcbm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input mcbm_pkg::mcbm_req_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input mcbm_pkg::mcbm_rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one transaction in flight: no back-to-back accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// received word only on a successful receive
	a_recv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != mcbm_pkg::ST_OK) |-> (rsp.recv_data == '0))
		else $error("recv_data nonzero on failed transaction");

	// a granted slot implies success
	a_slot_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.slot != '0) |-> (rsp.status == mcbm_pkg::ST_OK))
		else $error("slot nonzero on failed transaction");

endmodule

bind multi_channel_bounded_mailbox mcbm_checker u_mcbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ dv/multi_channel_bounded_mailbox_tb.sv @@
// ----------------------------------------------------------------------------
// multi_channel_bounded_mailbox_tb
// Drives open, close, send, receive and broadcast transactions into the
// mailbox and predicts every response from a slot table kept alongside it.
// A directed opening covers the corner cases. Random phases follow with
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module multi_channel_bounded_mailbox_tb;

	localparam int CLK_HALF     = 6;
	localparam int PHASE_ITEMS  = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4 * (3 + mcbm_pkg::NUM_CHANNELS);

	// slot table predictor and store of expected responses
	class slot_table_model;
		bit                          open_flag [mcbm_pkg::NUM_CHANNELS];
		int unsigned                 cap       [mcbm_pkg::NUM_CHANNELS];
		int unsigned                 rd_pos    [mcbm_pkg::NUM_CHANNELS];
		int unsigned                 wr_pos    [mcbm_pkg::NUM_CHANNELS];
		int unsigned                 fill      [mcbm_pkg::NUM_CHANNELS];
		logic [mcbm_pkg::WORD_W-1:0] words     [mcbm_pkg::STORE_DEPTH];
		mcbm_pkg::mcbm_rsp_t         pending_rsp [$];
		int unsigned                 fail_count;

		function bit has_room(int unsigned c);
			return fill[c] < cap[c];
		endfunction

		function void clear_queue(int unsigned c);
			rd_pos[c] = 0;
			wr_pos[c] = 0;
			fill[c]   = 0;
		endfunction

		function void push_word(int unsigned c, logic [mcbm_pkg::WORD_W-1:0] w);
			words[c * mcbm_pkg::QUEUE_DEPTH + wr_pos[c]] = w;
			wr_pos[c] = (wr_pos[c] + 1) % mcbm_pkg::QUEUE_DEPTH;
			fill[c]++;
		endfunction

		// work out the response to one accepted request and queue it
		function void note_request(mcbm_pkg::mcbm_req_t r);
			mcbm_pkg::mcbm_rsp_t e;
			int unsigned         c;
			bit                  found;
			bit                  any_open;
			bit                  all_room;
			e        = '0;
			e.status = mcbm_pkg::ST_NO_CHANNEL;
			c        = 32'(r.channel);
			found    = 1'b0;
			any_open = 1'b0;
			all_room = 1'b1;
			case (r.op)
				mcbm_pkg::OP_OPEN: begin
					e.status = mcbm_pkg::ST_TABLE_FULL;
					for (int i = 0; i < mcbm_pkg::NUM_CHANNELS; i++) begin
						if (!found && !open_flag[i]) begin
							found        = 1'b1;
							open_flag[i] = 1'b1;
							cap[i]       = (32'(r.limit) > mcbm_pkg::QUEUE_DEPTH) ?
								mcbm_pkg::QUEUE_DEPTH : 32'(r.limit);
							clear_queue(i);
							e.status     = mcbm_pkg::ST_OK;
							e.slot       = mcbm_pkg::CHAN_W'(i);
						end
					end
				end
				mcbm_pkg::OP_CLOSE: begin
					if (open_flag[c]) begin
						open_flag[c] = 1'b0;
						clear_queue(c);
						e.status = mcbm_pkg::ST_OK;
					end
				end
				mcbm_pkg::OP_SEND: begin
					if (open_flag[c]) begin
						if (has_room(c)) begin
							push_word(c, r.send_data);
							e.status = mcbm_pkg::ST_OK;
						end else begin
							e.status = mcbm_pkg::ST_WOULD_BLOCK;
						end
					end
				end
				mcbm_pkg::OP_RECEIVE: begin
					if (open_flag[c]) begin
						if (fill[c] != 0) begin
							e.recv_data = words[c * mcbm_pkg::QUEUE_DEPTH + rd_pos[c]];
							rd_pos[c]   = (rd_pos[c] + 1) % mcbm_pkg::QUEUE_DEPTH;
							fill[c]--;
							e.status    = mcbm_pkg::ST_OK;
						end else begin
							e.status = mcbm_pkg::ST_WOULD_BLOCK;
						end
					end
				end
				mcbm_pkg::OP_BROADCAST: begin
					for (int i = 0; i < mcbm_pkg::NUM_CHANNELS; i++) begin
						if (open_flag[i]) begin
							any_open = 1'b1;
							if (!has_room(i)) begin
								all_room = 1'b0;
							end
						end
					end
					if (!any_open) begin
						e.status = mcbm_pkg::ST_NO_CHANNEL;
					end else if (!all_room) begin
						e.status = mcbm_pkg::ST_WOULD_BLOCK;
					end else begin
						for (int i = 0; i < mcbm_pkg::NUM_CHANNELS; i++) begin
							if (open_flag[i]) begin
								push_word(i, r.send_data);
							end
						end
						e.status = mcbm_pkg::ST_OK;
					end
				end
				default: begin
				end
			endcase
			pending_rsp = {pending_rsp, e};
		endfunction

		function void check_response(mcbm_pkg::mcbm_rsp_t r);
			mcbm_pkg::mcbm_rsp_t e;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with nothing expected, got status %0d data %h slot %0d",
					$time, r.status, r.recv_data, r.slot);
				fail_count++;
				return;
			end
			e = pending_rsp[0];
			pending_rsp.delete(0);
			if (r.status !== e.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, r.status);
				fail_count++;
			end
			if (r.recv_data !== e.recv_data) begin
				$display("%0t: recv_data mismatch, expected %h, got %h",
					$time, e.recv_data, r.recv_data);
				fail_count++;
			end
			if (r.slot !== e.slot) begin
				$display("%0t: slot mismatch, expected %0d, got %0d", $time, e.slot, r.slot);
				fail_count++;
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	mcbm_pkg::mcbm_req_t req       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	mcbm_pkg::mcbm_rsp_t rsp;

	slot_table_model table_model = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off_request = 0;
	int unsigned hold_off_left = 0;

	multi_channel_bounded_mailbox i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #(CLK_HALF) clk = ~clk;

	// receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_off_request != 0) begin
			hold_off_left = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_off_left != 0) begin
			hold_off_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			table_model.check_response(rsp);
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycles);
		$display("RESULT: ERROR");
		$finish;
	end

	function mcbm_pkg::mcbm_req_t make_req(logic [mcbm_pkg::OP_W-1:0] op,
			logic [mcbm_pkg::CHAN_W-1:0] ch, logic [mcbm_pkg::WORD_W-1:0] data,
			logic [mcbm_pkg::LIMIT_W-1:0] lim);
		mcbm_pkg::mcbm_req_t r;
		r.op        = op;
		r.channel   = ch;
		r.send_data = data;
		r.limit     = lim;
		return r;
	endfunction

	// mostly well-formed traffic aimed at open slots, with some noise
	function mcbm_pkg::mcbm_req_t random_req();
		mcbm_pkg::mcbm_req_t r;
		int unsigned         pick;
		int unsigned         open_list [mcbm_pkg::NUM_CHANNELS];
		int unsigned         open_cnt;
		open_cnt = 0;
		for (int i = 0; i < mcbm_pkg::NUM_CHANNELS; i++) begin
			open_list[i] = 0;
			if (table_model.open_flag[i]) begin
				open_list[open_cnt] = i;
				open_cnt++;
			end
		end
		r.send_data = $urandom();
		r.limit     = mcbm_pkg::LIMIT_W'($urandom_range(31));
		if (open_cnt != 0 && $urandom_range(99) < 85) begin
			r.channel = mcbm_pkg::CHAN_W'(open_list[$urandom_range(open_cnt - 1)]);
		end else begin
			r.channel = mcbm_pkg::CHAN_W'($urandom_range(mcbm_pkg::NUM_CHANNELS - 1));
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			r.op = mcbm_pkg::OP_OPEN;
			pick = $urandom_range(99);
			if (pick < 5) begin
				r.limit = '0;
			end else if (pick < 15) begin
				r.limit = mcbm_pkg::LIMIT_W'($urandom_range(31, mcbm_pkg::QUEUE_DEPTH + 1));
			end else begin
				r.limit = mcbm_pkg::LIMIT_W'($urandom_range(mcbm_pkg::QUEUE_DEPTH, 1));
			end
		end else if (pick < 17) begin
			r.op = mcbm_pkg::OP_CLOSE;
		end else if (pick < 50) begin
			r.op = mcbm_pkg::OP_SEND;
		end else if (pick < 83) begin
			r.op = mcbm_pkg::OP_RECEIVE;
		end else if (pick < 95) begin
			r.op = mcbm_pkg::OP_BROADCAST;
		end else begin
			r.op = mcbm_pkg::OP_W'($urandom_range(7, 5));
		end
		return r;
	endfunction

	task drive_req(input mcbm_pkg::mcbm_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!req_ready);
		table_model.note_request(r);
		@(negedge clk);
	endtask

	task run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned hold_cycles);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		hold_off_request = hold_cycles;
		repeat (PHASE_ITEMS) begin
			drive_req(random_req());
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// nothing open yet
		drive_req(make_req(mcbm_pkg::OP_BROADCAST, 3'd0, 32'hFFFF_FFFF, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_SEND, 3'd7, 32'h1234_5678, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_RECEIVE, 3'd0, 32'h0, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_CLOSE, 3'd3, 32'h0, 5'd0));
		// undefined ops
		drive_req(make_req(3'd5, 3'd7, 32'hFFFF_FFFF, 5'd31));
		drive_req(make_req(3'd6, 3'd1, 32'h0, 5'd0));
		drive_req(make_req(3'd7, 3'd7, 32'hFFFF_FFFF, 5'd31));
		// zero capacity slot blocks send and broadcast
		drive_req(make_req(mcbm_pkg::OP_OPEN, 3'd5, 32'h0, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_SEND, 3'd0, 32'hDEAD_BEEF, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_BROADCAST, 3'd0, 32'hDEAD_BEEF, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_CLOSE, 3'd0, 32'h0, 5'd0));
		// saturating limit, then a one-word slot
		drive_req(make_req(mcbm_pkg::OP_OPEN, 3'd0, 32'h0, 5'd31));
		drive_req(make_req(mcbm_pkg::OP_OPEN, 3'd0, 32'h0, 5'd1));
		drive_req(make_req(mcbm_pkg::OP_SEND, 3'd1, 32'h0000_0000, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_SEND, 3'd1, 32'h5555_5555, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_BROADCAST, 3'd0, 32'hA5A5_A5A5, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_RECEIVE, 3'd1, 32'h0, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_RECEIVE, 3'd1, 32'h0, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_BROADCAST, 3'd0, 32'hFFFF_FFFF, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_RECEIVE, 3'd0, 32'h0, 5'd0));
		drive_req(make_req(mcbm_pkg::OP_OPEN, 3'd0, 32'h0, 5'd16));
		// fill the table until open reports it full
		repeat (6) begin
			drive_req(make_req(mcbm_pkg::OP_OPEN, 3'd0, 32'h0, 5'd8));
		end

		run_phase(0, 0, 0);
		run_phase(52, 0, 0);
		// long receiver hold-off while the sender keeps pushing
		run_phase(0, 52, 400);
		run_phase(33, 33, 0);
		req_valid <= 1'b0;

		while (table_model.pending_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (table_model.fail_count == 0 && table_model.pending_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
